@@ rtl/core/gf2rref_pkg.sv @@
// ============================================================================
// GF(2) RREF solver package
// Shared widths, defaults, request and result types, and sequencer states.
// ============================================================================
package gf2rref_pkg;

    // Width of a coefficient row and of a solution vector.
    localparam int VecW  = 32;
    // Width of a column index inside a vector.
    localparam int PivW  = 5;
    // Width of the num_vars register.
    localparam int NvarW = 6;

    // Default sizes handed to the top level.
    localparam int MaxVarsDef = 32;
    localparam int MaxRowsDef = 64;

    // Kind of a result.
    typedef enum logic [1:0] {
        KIND_PARTICULAR = 2'd0,
        KIND_KERNEL     = 2'd1,
        KIND_NO_SOLN    = 2'd2,
        KIND_OVERFLOW   = 2'd3
    } kind_t;

    // One row request.
    typedef struct packed {
        logic [VecW-1:0] row_coeffs;
        logic            row_rhs;
        logic            last_row;
    } row_req_t;

    // One result.
    typedef struct packed {
        logic [VecW-1:0] solution_vector;
        kind_t           result_kind;
        logic            last_result;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_EV,
        ST_KSCAN,
        ST_KER_RD,
        ST_KER_EV
    } state_t;

endpackage

@@ rtl/core/gf2_rref_solution_and_kernel_top.sv @@
// ============================================================================
// GF(2) RREF solution and kernel
// Stores the rows of a reduced echelon matrix, then walks them to emit the
// particular solution and one kernel basis vector per free column, or a failure result.
// ============================================================================
// Loading: one row per cycle when idle; a row that is not the last gives no result.
// Solve: the last row starts a pivot walk that reads and evaluates each stored row
// in turn, then each free column walks the pivot rows and each pivot column is skipped.
// Particular solution after the pivot walk; overflow in the cycle after the last row;
// busy stays high for the whole solve and results cannot be stalled by the receiver.
// Reset clears the sequencer, row count and overflow flag, sets num_vars to 32.
module gf2_rref_solution_and_kernel_top #(
    parameter int MAX_VARS = gf2rref_pkg::MaxVarsDef,
    parameter int MAX_ROWS = gf2rref_pkg::MaxRowsDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Row requests.
    input  logic                             start,
    output logic                             busy,
    input  gf2rref_pkg::row_req_t            row,
    // Results.
    output logic                             result_strobe,
    output gf2rref_pkg::result_t             result,
    // Configuration write channel for num_vars.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gf2rref_pkg::NvarW-1:0]    cfg_data
);

    localparam int VW    = gf2rref_pkg::VecW;
    localparam int PW    = gf2rref_pkg::PivW;
    localparam int NW    = gf2rref_pkg::NvarW;
    localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = $clog2(MAX_ROWS + 1);
    localparam int NvLim = (MAX_VARS < VW) ? MAX_VARS : VW;

    // Registers.
    gf2rref_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]        rows_reg, rows_next;
    logic                 ovf_reg, ovf_next;
    logic [NW-1:0]        nv_reg, nv_next;
    logic [CW-1:0]        r_reg, r_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        npiv_reg, npiv_next;
    logic [NW-1:0]        col_reg, col_next;
    logic                 done_reg, done_next;
    logic                 bad_reg, bad_next;
    logic [VW-1:0]        pmask_reg, pmask_next;
    logic [VW-1:0]        sol_reg, sol_next;
    logic [NW-1:0]        f_reg, f_next;
    logic [VW-1:0]        vec_reg, vec_next;
    gf2rref_pkg::result_t res_reg, res_next;
    logic                 strobe_reg, strobe_next;

    // Memories and their ports.
    logic [VW:0]          row_mem [MAX_ROWS];
    logic [PW-1:0]        piv_mem [MAX_ROWS];
    logic [VW:0]          row_rd_reg;
    logic [PW-1:0]        piv_rd_reg;
    logic                 row_we;
    logic [AW-1:0]        row_waddr;
    logic                 piv_we;
    logic [PW-1:0]        piv_wdata;
    logic [AW-1:0]        rd_addr;

    // Column masks and pivot search.
    logic [NW-1:0]        nv_eff;
    logic [VW-1:0]        colmask;
    logic [VW-1:0]        gemask;
    logic [VW-1:0]        above_f;
    logic [VW-1:0]        cand;
    logic [VW-1:0]        iso;
    logic [PW-1:0]        piv_idx;
    logic                 more_free;
    logic                 has_room;
    logic [CW-1:0]        r_inc;

    assign nv_eff   = (nv_reg > NW'(NvLim)) ? NW'(NvLim) : nv_reg;
    assign has_room = (rows_reg < CW'(MAX_ROWS));
    assign r_inc    = r_reg + CW'(1);
    assign rd_addr  = r_reg[AW-1:0];

    // Masks of valid columns, columns at or above the search start, and
    // columns above the current free column.
    always_comb
    begin
        for (int i = 0; i < VW; i++)
        begin
            colmask[i] = (NW'(i) < nv_eff);
            gemask[i]  = (NW'(i) >= col_reg);
            above_f[i] = (NW'(i) > f_reg);
        end
    end

    // Lowest set bit of the masked row, isolated and then encoded.
    assign cand = row_rd_reg[VW-1:0] & colmask & gemask;
    assign iso  = cand & (~cand + VW'(1));

    always_comb
    begin
        piv_idx = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (iso[i])
            begin
                piv_idx = piv_idx | PW'(i);
            end
        end
    end

    // A free column remains after the current one.
    assign more_free = |(~pmask_reg & colmask & above_f);

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gf2rref_pkg::ST_IDLE;
            rows_reg   <= '0;
            ovf_reg    <= 1'b0;
            nv_reg     <= NW'(32);
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rows_reg   <= rows_next;
            ovf_reg    <= ovf_next;
            nv_reg     <= nv_next;
            strobe_reg <= strobe_next;
        end
    end

    // Working registers of the solve.
    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        n_reg     <= n_next;
        npiv_reg  <= npiv_next;
        col_reg   <= col_next;
        done_reg  <= done_next;
        bad_reg   <= bad_next;
        pmask_reg <= pmask_next;
        sol_reg   <= sol_next;
        f_reg     <= f_next;
        vec_reg   <= vec_next;
        res_reg   <= res_next;
    end

    // Row memory and pivot memory, one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= {row.row_rhs, row.row_coeffs};
        end
        if (piv_we)
        begin
            piv_mem[rd_addr] <= piv_wdata;
        end
        row_rd_reg <= row_mem[rd_addr];
        piv_rd_reg <= piv_mem[rd_addr];
    end

    // Sequencer: next state, working values and results.
    always_comb
    begin
        logic over;
        logic done_new;
        logic bad_new;
        logic [VW-1:0] pmask_new;
        logic [VW-1:0] sol_new;
        logic [VW-1:0] vec_new;

        state_next  = state_reg;
        rows_next   = rows_reg;
        ovf_next    = ovf_reg;
        nv_next     = nv_reg;
        r_next      = r_reg;
        n_next      = n_reg;
        npiv_next   = npiv_reg;
        col_next    = col_reg;
        done_next   = done_reg;
        bad_next    = bad_reg;
        pmask_next  = pmask_reg;
        sol_next    = sol_reg;
        f_next      = f_reg;
        vec_next    = vec_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        row_we      = 1'b0;
        row_waddr   = rows_reg[AW-1:0];
        piv_we      = 1'b0;
        piv_wdata   = piv_idx;
        over        = 1'b0;
        done_new    = done_reg;
        bad_new     = bad_reg;
        pmask_new   = pmask_reg;
        sol_new     = sol_reg;
        vec_new     = vec_reg;

        if (cfg_valid && cfg_ready)
        begin
            nv_next = cfg_data;
        end

        case (state_reg)
            gf2rref_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // Store the row, or note the overflow when the memory is full.
                    if (has_room)
                    begin
                        row_we    = 1'b1;
                        rows_next = rows_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (row.last_row)
                    begin
                        over      = ovf_reg || !has_room;
                        n_next    = rows_next;
                        rows_next = '0;
                        ovf_next  = 1'b0;
                        if (over)
                        begin
                            res_next    = '{solution_vector: '0,
                                            result_kind: gf2rref_pkg::KIND_OVERFLOW,
                                            last_result: 1'b1};
                            strobe_next = 1'b1;
                        end
                        else
                        begin
                            r_next     = '0;
                            npiv_next  = '0;
                            col_next   = '0;
                            done_next  = 1'b0;
                            bad_next   = 1'b0;
                            pmask_next = '0;
                            sol_next   = '0;
                            state_next = gf2rref_pkg::ST_PIV_RD;
                        end
                    end
                end
            end

            gf2rref_pkg::ST_PIV_RD:
            begin
                state_next = gf2rref_pkg::ST_PIV_EV;
            end

            gf2rref_pkg::ST_PIV_EV:
            begin
                // Pivot of this row, or the end of the pivot rows.
                if (!done_reg)
                begin
                    if (cand != '0)
                    begin
                        piv_we    = 1'b1;
                        col_next  = NW'(piv_idx) + NW'(1);
                        pmask_new = pmask_reg | iso;
                        if (row_rd_reg[VW])
                        begin
                            sol_new = sol_reg | iso;
                        end
                        npiv_next = npiv_reg + CW'(1);
                    end
                    else
                    begin
                        done_new = 1'b1;
                    end
                end
                if (done_new && row_rd_reg[VW])
                begin
                    bad_new = 1'b1;
                end
                done_next  = done_new;
                bad_next   = bad_new;
                pmask_next = pmask_new;
                sol_next   = sol_new;
                r_next     = r_inc;
                if (r_inc == n_reg)
                begin
                    strobe_next = 1'b1;
                    if (bad_new)
                    begin
                        res_next   = '{solution_vector: '0,
                                       result_kind: gf2rref_pkg::KIND_NO_SOLN,
                                       last_result: 1'b1};
                        state_next = gf2rref_pkg::ST_IDLE;
                    end
                    else
                    begin
                        res_next = '{solution_vector: sol_new,
                                     result_kind: gf2rref_pkg::KIND_PARTICULAR,
                                     last_result: ~|(~pmask_new & colmask)};
                        f_next   = '0;
                        if (~|(~pmask_new & colmask))
                        begin
                            state_next = gf2rref_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = gf2rref_pkg::ST_KSCAN;
                        end
                    end
                end
                else
                begin
                    state_next = gf2rref_pkg::ST_PIV_RD;
                end
            end

            gf2rref_pkg::ST_KSCAN:
            begin
                // Skip pivot columns; a free column starts a walk over pivot rows.
                if (pmask_reg[f_reg[PW-1:0]])
                begin
                    f_next = f_reg + NW'(1);
                end
                else
                begin
                    vec_new  = VW'(1) << f_reg[PW-1:0];
                    vec_next = vec_new;
                    r_next   = '0;
                    if (npiv_reg == '0)
                    begin
                        res_next    = '{solution_vector: vec_new,
                                        result_kind: gf2rref_pkg::KIND_KERNEL,
                                        last_result: !more_free};
                        strobe_next = 1'b1;
                        f_next      = f_reg + NW'(1);
                        if (!more_free)
                        begin
                            state_next = gf2rref_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = gf2rref_pkg::ST_KER_RD;
                    end
                end
            end

            gf2rref_pkg::ST_KER_RD:
            begin
                state_next = gf2rref_pkg::ST_KER_EV;
            end

            gf2rref_pkg::ST_KER_EV:
            begin
                // A pivot row with the free column set adds its pivot bit.
                if (row_rd_reg[f_reg[PW-1:0]])
                begin
                    vec_new = vec_reg | (VW'(1) << piv_rd_reg);
                end
                vec_next = vec_new;
                r_next   = r_inc;
                if (r_inc == npiv_reg)
                begin
                    res_next    = '{solution_vector: vec_new,
                                    result_kind: gf2rref_pkg::KIND_KERNEL,
                                    last_result: !more_free};
                    strobe_next = 1'b1;
                    f_next      = f_reg + NW'(1);
                    if (!more_free)
                    begin
                        state_next = gf2rref_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = gf2rref_pkg::ST_KSCAN;
                    end
                end
                else
                begin
                    state_next = gf2rref_pkg::ST_KER_RD;
                end
            end

            default:
            begin
                state_next = gf2rref_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    assign busy          = (state_reg != gf2rref_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == gf2rref_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    // A result only follows a request or an active solve.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy || start))
        else $error("result strobe without a request or solve");

    // Failure results are always final and carry an empty vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.result_kind == gf2rref_pkg::KIND_NO_SOLN ||
                          result.result_kind == gf2rref_pkg::KIND_OVERFLOW)
        |-> result.last_result && (result.solution_vector == '0))
        else $error("failure result not final or not empty");

    // The final result leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last_result |-> !busy)
        else $error("busy after the final result");

    // While solving, the row count and overflow flag are already cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rows_reg == '0) && !ovf_reg)
        else $error("row count not cleared during solve");

endmodule
